FILE: sv/i2p_pkg.sv
`timescale 1ns / 1ps

package i2p_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;

    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNMATCHED = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expression;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       has_symbol;
        logic       last;
        logic [1:0] status;
    } out_item_t;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
        else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
        else if (c == CH_CARET) p = 2'd3;
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)
            || (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

FILE: sv/infix_to_postfix_converter_core.sv
`timescale 1ns / 1ps

// infix to postfix converter (shunting-yard)
// item channel (item_valid / item_stall / item): one ASCII character per
// transaction, end_of_expression set on the final character of an expression.
// result channel (result_valid / result_stall / result): postfix characters,
// marker transactions (has_symbol 0) carry a status code or close an
// expression whose final character produced nothing; last is set on the final result.
// item_stall is high while a character is being processed; the block takes
// one character at a time. an operand is registered on acceptance and goes
// to the output register from the S_OPND state; '(' is pushed directly.
// every stack inspection is a registered read of the operator stack memory
// (S_READ), then the decision (S_DECIDE), repeated for each operator popped;
// an overflow or a stray ')' gets its own marker step. the end-of-expression
// flush reads and pops each stacked symbol in turn. a step that wants to emit
// waits while the output register holds a result that result_stall keeps back.
// reset (rst_n low, asynchronous) empties the stack and drops any pending
// result; stack contents need no clearing.
module infix_to_postfix_converter_core
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_OPND   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_PUSH   = 4'd4;
    localparam logic [3:0] S_OVF    = 4'd5;
    localparam logic [3:0] S_STRAY  = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_FREAD  = 4'd8;
    localparam logic [3:0] S_FPOP   = 4'd9;
    localparam logic [3:0] S_MARK   = 4'd10;

    logic [7:0]       stack_mem [STACK_DEPTH];
    logic [7:0]       rd_reg;
    logic [7:0]       rd2_reg;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sym_reg;
    logic             end_reg;
    logic             close_reg;
    logic [1:0]       prec_reg;
    logic             emitted_reg, emitted_next;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic             emit;
    out_item_t        emit_data;
    logic             out_free;
    logic             push_we;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;
    logic             accept;

    assign cnt_m1     = count_reg - ONE;
    assign cnt_m2     = count_reg - TWO;
    assign out_free   = !out_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result     = out_reg;

    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            stack_mem[count_reg[ADDR_W-1:0]] <= sym_reg;
        end
        rd_reg  <= stack_mem[cnt_m1[ADDR_W-1:0]];
        rd2_reg <= stack_mem[cnt_m2[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        emitted_next = emitted_reg;
        emit         = 1'b0;
        emit_data    = '{out_symbol: 8'd0, has_symbol: 1'b0, last: 1'b0, status: STATUS_OK};
        push_we      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    emitted_next = 1'b0;
                    if (is_operand(item.symbol)) state_next = S_OPND;
                    else if (item.symbol == CH_LPAREN) state_next = S_PUSH;
                    else state_next = S_READ;
                end
            end
            S_OPND:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.out_symbol = sym_reg;
                    emit_data.has_symbol = 1'b1;
                    emit_data.last = end_reg && (count_reg == '0);
                    state_next = S_FIN;
                end
            end
            S_READ:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (count_reg == '0)
                begin
                    state_next = close_reg ? S_STRAY : S_PUSH;
                end
                else if (rd_reg == CH_LPAREN)
                begin
                    if (close_reg)
                    begin
                        count_next = cnt_m1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (close_reg || prec_of(rd_reg) >= prec_reg)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        emit_data.out_symbol = rd_reg;
                        emit_data.has_symbol = 1'b1;
                        // final pop when only the matching '(' remains below
                        emit_data.last = end_reg && close_reg && (count_reg == TWO)
                            && (rd2_reg == CH_LPAREN);
                        count_next = cnt_m1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (count_reg == FULL)
                begin
                    state_next = S_OVF;
                end
                else
                begin
                    push_we    = 1'b1;
                    count_next = count_reg + ONE;
                    state_next = S_FIN;
                end
            end
            S_OVF:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.status = STATUS_OVERFLOW;
                    state_next = S_FIN;
                end
            end
            S_STRAY:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.status = STATUS_UNMATCHED;
                    emit_data.last = end_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!end_reg) state_next = S_IDLE;
                else if (count_reg != '0) state_next = S_FREAD;
                else if (!emitted_reg) state_next = S_MARK;
                else state_next = S_IDLE;
            end
            S_FREAD:
            begin
                state_next = S_FPOP;
            end
            S_FPOP:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.out_symbol = rd_reg;
                    emit_data.has_symbol = 1'b1;
                    emit_data.last = (count_reg == ONE);
                    count_next = cnt_m1;
                    state_next = (count_reg == ONE) ? S_IDLE : S_FREAD;
                end
            end
            S_MARK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_data.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (emit) emitted_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            emitted_reg <= emitted_next;
            if (emit) out_valid_reg <= 1'b1;
            else if (!result_stall) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg   <= item.symbol;
            end_reg   <= item.end_of_expression;
            close_reg <= (item.symbol == CH_RPAREN);
            prec_reg  <= prec_of(item.symbol);
        end
        if (emit)
        begin
            out_reg <= emit_data;
        end
    end

    // stack never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL)
        else $error("stack count beyond depth");

    // a new result never overwrites one held back by the receiver
    assert property (@(posedge clk) disable iff (!rst_n) emit |-> out_free)
        else $error("result overwritten while stalled");

    // error codes only travel on marker results
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_OK || !result.has_symbol))
        else $error("status on a symbol result");

    // a push onto a full stack must raise the overflow marker
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && count_reg == FULL) |=> state_reg == S_OVF)
        else $error("full stack push not flagged");

    // a held result stays put while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule
